[rtl/core/lkv_pkg.sv]
// Package for the LRU key-value cache: shared types and operation codes.
// No dependencies.
`timescale 1ns / 1ps
package lkv_pkg;
	localparam logic REQ_GET = 1'b0;
	localparam logic REQ_PUT = 1'b1;
	localparam int KEY_W = 32;
	localparam int OUT_W = 32;
	localparam int CAP_W = 5;

	typedef struct packed {
		logic req_type;
		logic [KEY_W-1:0] key;
		logic [OUT_W-1:0] value_in;
	} req_t;

	typedef struct packed {
		logic hit;
		logic [OUT_W-1:0] read_value;
		logic evicted;
		logic [OUT_W-1:0] evicted_value;
	} rsp_t;
endpackage

[rtl/core/lkv_if.sv]
// Valid/ready channel interface carrying a payload of type T.
// Depends on nothing.
`timescale 1ns / 1ps
interface lkv_if #(parameter type T = logic) (input logic clk);
	logic valid;
	logic ready;
	T data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/core/lkv_front.sv]
// Front part: accepts requests and holds them in a two-deep queue for the back part.
// Depends on lkv_pkg.
`timescale 1ns / 1ps
module lkv_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input lkv_pkg::req_t in_data,
	output logic q_valid,
	input logic q_ready,
	output lkv_pkg::req_t q_data
);
	lkv_pkg::req_t buf_q [2];
	logic wr_q, rd_q;
	logic [1:0] cnt_q;

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign q_data = buf_q[rd_q];

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			buf_q[wr_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (in_valid && in_ready) wr_q <= ~wr_q;
			if (q_valid && q_ready) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, in_valid && in_ready} - {1'b0, q_valid && q_ready};
		end
	end
endmodule

[rtl/core/lkv_back.sv]
// Back part: walks the entries, updates recency ranks, builds the result.
// Depends on lkv_pkg.
`timescale 1ns / 1ps
module lkv_back #(
	parameter int MAX_ENTRIES = 16,
	parameter int VALUE_BITS = 32
) (
	input logic clk,
	input logic arst_n,
	input logic [lkv_pkg::CAP_W-1:0] capacity,
	input logic q_valid,
	output logic q_ready,
	input lkv_pkg::req_t q_data,
	output logic out_valid,
	input logic out_ready,
	output lkv_pkg::rsp_t out_data
);
	localparam int IW = $clog2(MAX_ENTRIES);
	localparam int NW = $clog2(MAX_ENTRIES + 1);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_FIND = 2'd1;
	localparam logic [1:0] ST_UPD = 2'd2;
	localparam logic [1:0] ST_OUT = 2'd3;

	logic [lkv_pkg::KEY_W-1:0] key_q [MAX_ENTRIES];
	logic [VALUE_BITS-1:0] val_q [MAX_ENTRIES];
	logic [IW-1:0] rank_q [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] vld_q;
	logic [NW-1:0] count_q;
	logic [1:0] state_q;
	lkv_pkg::req_t req_q;
	logic [MAX_ENTRIES-1:0] match_q;
	lkv_pkg::rsp_t rsp_q;

	logic [MAX_ENTRIES-1:0] match_c;
	logic [IW-1:0] slot_c, old_c;
	logic found_c, old_ok_c;
	logic [NW-1:0] cap_c;
	logic [VALUE_BITS-1:0] vin;

	assign vin = VALUE_BITS'(req_q.value_in);

	always_comb begin
		if (capacity == '0) cap_c = NW'(1);
		else if (int'(capacity) > MAX_ENTRIES) cap_c = NW'(MAX_ENTRIES);
		else cap_c = NW'(capacity);
	end

	always_comb begin
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			match_c[i] = vld_q[i] && (key_q[i] == req_q.key);
		end
	end

	always_comb begin
		found_c = 1'b0;
		slot_c = '0;
		old_c = '0;
		old_ok_c = 1'b0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (match_q[i] && !found_c) begin
				found_c = 1'b1;
				slot_c = IW'(i);
			end
			if (vld_q[i] && rank_q[i] == IW'(count_q - NW'(1)) && !old_ok_c) begin
				old_ok_c = 1'b1;
				old_c = IW'(i);
			end
		end
	end

	assign q_ready = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign out_data = rsp_q;

	logic is_put_c;
	logic evict_c;
	logic [MAX_ENTRIES-1:0] vld_after;
	logic [MAX_ENTRIES-1:0] vld_new;
	logic [IW-1:0] ins_c;
	logic ins_ok;
	lkv_pkg::rsp_t rsp_c;

	always_comb begin
		is_put_c = (req_q.req_type == lkv_pkg::REQ_PUT);
		evict_c = !found_c && is_put_c && count_q >= cap_c && count_q != '0;
		vld_after = vld_q;
		if (evict_c) vld_after[old_c] = 1'b0;
		ins_ok = 1'b0;
		ins_c = '0;
		for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
			if (!vld_after[i]) begin
				ins_ok = 1'b1;
				ins_c = IW'(i);
			end
		end
		vld_new = vld_after;
		if (ins_ok) vld_new[ins_c] = 1'b1;
		rsp_c = '0;
		if (found_c) begin
			rsp_c.hit = 1'b1;
			if (!is_put_c) rsp_c.read_value = lkv_pkg::OUT_W'(val_q[slot_c]);
		end else if (evict_c) begin
			rsp_c.evicted = 1'b1;
			rsp_c.evicted_value = lkv_pkg::OUT_W'(val_q[old_c]);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && q_valid) begin
			req_q <= q_data;
		end
		if (state_q == ST_FIND) begin
			match_q <= match_c;
		end
		if (state_q == ST_UPD) begin
			rsp_q <= rsp_c;
			if (found_c) begin
				if (is_put_c) val_q[slot_c] <= vin;
				for (int i = 0; i < MAX_ENTRIES; i++) begin
					if (vld_q[i] && rank_q[i] < rank_q[slot_c]) rank_q[i] <= rank_q[i] + 1'b1;
				end
				rank_q[slot_c] <= '0;
			end else if (is_put_c && ins_ok) begin
				for (int i = 0; i < MAX_ENTRIES; i++) begin
					if (vld_after[i]) rank_q[i] <= rank_q[i] + 1'b1;
				end
				key_q[ins_c] <= req_q.key;
				val_q[ins_c] <= vin;
				rank_q[ins_c] <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			vld_q <= '0;
			count_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: if (q_valid) state_q <= ST_FIND;
				ST_FIND: state_q <= ST_UPD;
				ST_UPD: begin
					if (!found_c && is_put_c) begin
						vld_q <= vld_new;
						count_q <= count_q - NW'(evict_c) + NW'(ins_ok);
					end
					state_q <= ST_OUT;
				end
				ST_OUT: if (out_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

[rtl/core/lru_key_value_cache.sv]
// Top level of the LRU key-value cache: request queue, lookup engine, capacity register.
// Depends on lkv_pkg, lkv_if, lkv_front and lkv_back.
`timescale 1ns / 1ps
// A request passes four steps in the lookup engine (load, compare all keys, update ranks,
// present the result); a new request is taken only after the last result is accepted.
// A two-item queue in front lets requests arrive while the engine works. Capacity writes
// apply from the next update step; zero acts as one, values above MAX_ENTRIES saturate.
module lru_key_value_cache #(
	parameter int MAX_ENTRIES = 16,
	parameter int VALUE_BITS = 32
) (
	input logic clk,
	input logic arst_n,
	lkv_if.sink req,
	lkv_if.source rsp,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [lkv_pkg::CAP_W-1:0] cfg_data
);
	logic [lkv_pkg::CAP_W-1:0] capacity_q;
	logic q_valid, q_ready;
	lkv_pkg::req_t q_data;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) capacity_q <= lkv_pkg::CAP_W'(16);
		else if (cfg_valid) capacity_q <= cfg_data;
	end

	lkv_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(req.valid), .in_ready(req.ready), .in_data(req.data),
		.q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
	);

	lkv_back #(.MAX_ENTRIES(MAX_ENTRIES), .VALUE_BITS(VALUE_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .capacity(capacity_q),
		.q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
		.out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(rsp.data)
	);

	a_evict_put: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.evicted |-> !rsp.data.hit)
		else $error("eviction reported on a hit");
	a_ev_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.data.evicted |-> rsp.data.evicted_value == '0)
		else $error("evicted value without eviction");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
		else $error("result dropped while stalled");
endmodule

[verif/tb_lru_key_value_cache.sv]
// Self-checking testbench for the LRU key-value cache: drives get and put items with random
// idling on both channels, predicts each result with its own recency table and compares.
// Depends on lkv_pkg, lkv_if and lru_key_value_cache.
`timescale 1ns / 1ps
module tb_lru_key_value_cache;
	localparam int DEPTH = 16;
	localparam int WATCHDOG_LIMIT = 5000;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [lkv_pkg::CAP_W-1:0] cfg_data;

	lkv_if #(.T(lkv_pkg::req_t)) req (.clk(clk));
	lkv_if #(.T(lkv_pkg::rsp_t)) rsp (.clk(clk));

	lru_key_value_cache u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	logic [31:0] slot_key [DEPTH];
	logic [31:0] slot_value [DEPTH];
	bit slot_used [DEPTH];
	int unsigned slot_rank [DEPTH];
	int unsigned used_count;
	int unsigned cap_reg;

	lkv_pkg::rsp_t pending_rsp [$];
	int unsigned mismatch_count;
	int unsigned idle_cycles;
	bit quiet_phase;
	logic [31:0] recent_keys [$];

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic void cache_clear();
		for (int i = 0; i < DEPTH; i++) begin
			slot_used[i] = 1'b0;
		end
		used_count = 0;
		cap_reg = 16;
	endfunction

	function automatic void make_newest(int s);
		int unsigned r;
		r = slot_rank[s];
		for (int i = 0; i < DEPTH; i++) begin
			if (slot_used[i] && slot_rank[i] < r) begin
				slot_rank[i]++;
			end
		end
		slot_rank[s] = 0;
	endfunction

	function automatic lkv_pkg::rsp_t cache_access(lkv_pkg::req_t r);
		lkv_pkg::rsp_t o;
		int s;
		int victim;
		int free_slot;
		int unsigned eff_cap;
		int unsigned oldest;
		o = '0;
		s = -1;
		victim = -1;
		free_slot = -1;
		oldest = 0;
		eff_cap = (cap_reg == 0) ? 1 : ((cap_reg > DEPTH) ? DEPTH : cap_reg);
		for (int i = 0; i < DEPTH; i++) begin
			if (s < 0 && slot_used[i] && slot_key[i] == r.key) begin
				s = i;
			end
		end
		if (s >= 0) begin
			o.hit = 1'b1;
			if (r.req_type == lkv_pkg::REQ_PUT) begin
				slot_value[s] = r.value_in;
			end else begin
				o.read_value = slot_value[s];
			end
			make_newest(s);
		end else if (r.req_type == lkv_pkg::REQ_PUT) begin
			if (used_count >= eff_cap) begin
				for (int i = 0; i < DEPTH; i++) begin
					if (slot_used[i] && (victim < 0 || slot_rank[i] > oldest)) begin
						victim = i;
						oldest = slot_rank[i];
					end
				end
				if (victim >= 0) begin
					o.evicted = 1'b1;
					o.evicted_value = slot_value[victim];
					slot_used[victim] = 1'b0;
					used_count--;
				end
			end
			for (int i = 0; i < DEPTH; i++) begin
				if (free_slot < 0 && !slot_used[i]) begin
					free_slot = i;
				end
			end
			if (free_slot >= 0) begin
				for (int i = 0; i < DEPTH; i++) begin
					if (slot_used[i]) begin
						slot_rank[i]++;
					end
				end
				slot_used[free_slot] = 1'b1;
				slot_key[free_slot] = r.key;
				slot_value[free_slot] = r.value_in;
				slot_rank[free_slot] = 0;
				used_count++;
			end
		end
		return o;
	endfunction

	task automatic send_item(logic op, logic [31:0] k, logic [31:0] v);
		lkv_pkg::req_t r;
		r.req_type = op;
		r.key = k;
		r.value_in = v;
		if (!quiet_phase && $urandom_range(0, 3) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.data <= r;
		@(posedge clk);
		while (!req.ready) begin
			@(posedge clk);
		end
		pending_rsp.push_back(cache_access(r));
		recent_keys.push_back(k);
		if (recent_keys.size() > 24) begin
			void'(recent_keys.pop_front());
		end
	endtask

	task automatic wait_drained();
		req.valid <= 1'b0;
		while (pending_rsp.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
	endtask

	task automatic write_capacity(logic [lkv_pkg::CAP_W-1:0] c);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data <= c;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
		cap_reg = c;
	endtask

	function automatic logic [31:0] pick_key();
		if (recent_keys.size() != 0 && $urandom_range(0, 2) != 0) begin
			return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
		end
		case ($urandom_range(0, 3))
			0: return 32'h8000_0000 + $urandom_range(0, 3);
			1: return 32'h7FFF_FFFC + $urandom_range(0, 3);
			2: return $urandom_range(0, 20);
			default: return $urandom();
		endcase
	endfunction

	task automatic test_directed();
		send_item(lkv_pkg::REQ_GET, 32'h8000_0000, 32'hFFFF_FFFF);
		send_item(lkv_pkg::REQ_PUT, 32'h8000_0000, 32'hFFFF_FFFF);
		send_item(lkv_pkg::REQ_PUT, 32'h7FFF_FFFF, 32'h0000_0000);
		send_item(lkv_pkg::REQ_PUT, 32'hFFFF_FFFF, 32'hA5A5_5A5A);
		send_item(lkv_pkg::REQ_PUT, 32'h0000_0000, 32'h5A5A_A5A5);
		send_item(lkv_pkg::REQ_GET, 32'h8000_0000, 32'h1234_5678);
		send_item(lkv_pkg::REQ_GET, 32'h7FFF_FFFF, 32'h0);
		send_item(lkv_pkg::REQ_PUT, 32'hFFFF_FFFF, 32'h0BAD_F00D);
		send_item(lkv_pkg::REQ_GET, 32'hFFFF_FFFF, 32'h0);
		send_item(lkv_pkg::REQ_GET, 32'h0000_0001, 32'h0);
	endtask

	task automatic test_capacity_edges();
		write_capacity(5'd0);
		send_item(lkv_pkg::REQ_PUT, 32'd1, 32'd11);
		send_item(lkv_pkg::REQ_PUT, 32'd2, 32'd22);
		send_item(lkv_pkg::REQ_GET, 32'd1, 32'd0);
		send_item(lkv_pkg::REQ_GET, 32'd2, 32'd0);
		write_capacity(5'd31);
		for (int i = 0; i < 18; i++) begin
			send_item(lkv_pkg::REQ_PUT, 32'd100 + i, $urandom());
		end
		write_capacity(5'd2);
		send_item(lkv_pkg::REQ_PUT, 32'd500, 32'hDEAD_BEEF);
		send_item(lkv_pkg::REQ_PUT, 32'd501, 32'hCAFE_0001);
		send_item(lkv_pkg::REQ_GET, 32'd117, 32'd0);
	endtask

	task automatic test_random(int n);
		logic [lkv_pkg::CAP_W-1:0] caps [6] = '{5'd1, 5'd16, 5'd3, 5'd8, 5'd17, 5'd5};
		for (int p = 0; p < 6; p++) begin
			write_capacity(caps[p]);
			if (p == 5) begin
				quiet_phase = 1'b1;
			end
			for (int i = 0; i < n / 6; i++) begin
				send_item(logic'($urandom_range(0, 1)), pick_key(), $urandom());
			end
		end
	endtask

	always @(posedge clk) begin
		if (rsp.valid && rsp.ready) begin
			if (pending_rsp.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10) begin
					$display("Unexpected item: %p", rsp.data);
				end
			end else begin
				if (rsp.data !== pending_rsp[0]) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("Mismatch: expected %p, actual %p", pending_rsp[0], rsp.data);
					end
				end
				void'(pending_rsp.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else if (quiet_phase) begin
			rsp.ready <= 1'b1;
		end else if (rsp.ready && $urandom_range(0, 5) == 0) begin
			rsp.ready <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
			rsp.ready <= 1'b1;
		end else begin
			rsp.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.data = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		mismatch_count = 0;
		idle_cycles = 0;
		quiet_phase = 1'b0;
		cache_clear();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_capacity_edges();
		test_random(516);
		wait_drained();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && pending_rsp.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
